// File: design/tdwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdwd_pkg;

  localparam int RING_DEPTH = 128;

  // Ring address, fill count and accumulator widths all follow from the depth.
  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = 16 + FILL_W;
  localparam int WIN_W = (FILL_W > 8) ? FILL_W : 8;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  localparam logic [15:0] NO_READING = 16'h8000;
  localparam logic [3:0] SPM_RESET = 4'd6;
  localparam logic [15:0] THRESHOLD_RESET = 16'hFF38;

  localparam logic [WIN_W-1:0] WINDOW_SCALE = WIN_W'(10);
  localparam logic [WIN_W-1:0] OFFSET_SCALE = WIN_W'(13);
  localparam logic [9:0] TIMEOUT_SCALE = 10'd30;
  localparam logic [8:0] COUNT_MAX = 9'h1FF;

  typedef enum logic [1:0] {
    CFG_SAMPLES_PER_MINUTE = 2'd0,
    CFG_DROP_THRESHOLD = 2'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: design/tdwd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tdwd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/temperature_drop_window_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   temperature_sample
// output    out        out_valid/out_stall drop_detected, reference_average
// config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One probe at a time. A probe that needs no new average goes straight to the
// result; one that does waits for the one-entry-per-cycle sweep of the ring
// read port and for the bit-serial divider. The ring validity is tracked by a
// fill count, so reset needs no clearing pass. A stalled result holds the
// block in its final state.

module temperature_drop_window_detector (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] temperature_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             drop_detected,
  output logic [15:0]      reference_average,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IDX_W = tdwd_pkg::IDX_W;
  localparam int FILL_W = tdwd_pkg::FILL_W;
  localparam int SUM_W = tdwd_pkg::SUM_W;
  localparam int WIN_W = tdwd_pkg::WIN_W;
  localparam int DIV_CNT_W = tdwd_pkg::DIV_CNT_W;
  localparam logic [WIN_W-1:0] DEPTH_W = WIN_W'(tdwd_pkg::RING_DEPTH);
  localparam logic [WIN_W:0] DEPTH_X = (WIN_W + 1)'(tdwd_pkg::RING_DEPTH);
  localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(tdwd_pkg::RING_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(tdwd_pkg::RING_DEPTH - 1);

  tdwd_pkg::state_t state, state_next;

  logic [3:0]            spm;
  logic signed [15:0]    thr;
  logic [IDX_W-1:0]      wi;
  logic [FILL_W-1:0]     fill;
  logic                  detecting;
  logic [8:0]            count;
  logic [15:0]           saved_avg;
  logic [15:0]           sample;
  logic                  mode_det;
  logic                  computed;
  logic [IDX_W-1:0]      ptr;
  logic [WIN_W-1:0]      n;
  logic                  pend;
  logic                  pend_ok;
  logic signed [SUM_W-1:0] sum;
  logic [FILL_W-1:0]     cnt;
  logic [SUM_W-1:0]      quo;
  logic [FILL_W-1:0]     rem;
  logic                  neg;
  logic [DIV_CNT_W-1:0]  div_i;

  logic                  accept;
  logic                  out_free;
  logic                  ram_we;
  logic [15:0]           rdata;

  logic [WIN_W-1:0]      win_len;
  logic                  win_bad;
  logic [WIN_W-1:0]      off_raw;
  logic [WIN_W-1:0]      off_mod;
  logic [WIN_W:0]        from_sum;
  logic [IDX_W-1:0]      win_from;

  logic signed [16:0]    rise_diff;
  logic signed [16:0]    half_thr;
  logic signed [16:0]    thr_x;
  logic                  rise;

  logic signed [16:0]    drop_diff;
  logic                  check;
  logic                  det_keep;
  logic                  det_new;
  logic [9:0]            timeout_lim;

  logic [FILL_W:0]       rem_sh;
  logic                  q_bit;
  logic [SUM_W-1:0]      quo_res;
  logic [SUM_W-1:0]      sum_mag;

  assign cfg_ready = 1'b1;
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign ram_we = accept && (temperature_sample != tdwd_pkg::NO_READING);

  tdwd_ram #(
    .WIDTH(16),
    .DEPTH(tdwd_pkg::RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wi),
    .wdata(temperature_sample),
    .raddr(ptr),
    .rdata(rdata)
  );

  // Window geometry: the start wraps modulo the ring depth.
  always_comb begin
    win_len = WIN_W'(spm) * tdwd_pkg::WINDOW_SCALE;
    win_bad = (win_len == '0) || (win_len > DEPTH_W);
    off_raw = WIN_W'(spm) * tdwd_pkg::OFFSET_SCALE;
    off_mod = (off_raw >= DEPTH_W) ? (off_raw - DEPTH_W) : off_raw;
    from_sum = (WIN_W + 1)'(wi) + (WIN_W + 1)'(DEPTH_W - off_mod);
    if (from_sum >= DEPTH_X) begin
      from_sum = from_sum - DEPTH_X;
    end
    win_from = from_sum[IDX_W-1:0];
  end

  // The rise test uses the threshold halved with truncation toward zero.
  always_comb begin
    thr_x = {thr[15], thr};
    half_thr = (thr_x + $signed({16'd0, thr[15]})) >>> 1;
    rise_diff = $signed({temperature_sample[15], temperature_sample})
              - $signed({saved_avg[15], saved_avg});
    rise = rise_diff > half_thr;
  end

  always_comb begin
    drop_diff = $signed({sample[15], sample}) - $signed({saved_avg[15], saved_avg});
    check = computed && (saved_avg != tdwd_pkg::NO_READING) && (drop_diff < thr_x);
    timeout_lim = 10'(spm) * tdwd_pkg::TIMEOUT_SCALE;
    det_keep = computed ? check : 1'b1;
    if (mode_det) begin
      det_new = det_keep && !({1'b0, count} > timeout_lim);
    end else begin
      det_new = check;
    end
  end

  // One restoring divider step per cycle on the magnitude of the sum.
  always_comb begin
    rem_sh = {rem, quo[SUM_W-1]};
    q_bit = rem_sh >= {1'b0, cnt};
    quo_res = neg ? (~quo + SUM_W'(1)) : quo;
    sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdwd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall = (state != tdwd_pkg::ST_IDLE);
    unique case (state)
      tdwd_pkg::ST_IDLE: begin
        if (accept) begin
          if (detecting && !rise) begin
            state_next = tdwd_pkg::ST_DONE;
          end else begin
            state_next = tdwd_pkg::ST_START;
          end
        end
      end
      tdwd_pkg::ST_START: begin
        state_next = win_bad ? tdwd_pkg::ST_DONE : tdwd_pkg::ST_SUM;
      end
      tdwd_pkg::ST_SUM: begin
        if ((n == win_len) && !pend) begin
          state_next = (cnt == '0) ? tdwd_pkg::ST_DONE : tdwd_pkg::ST_DIV;
        end
      end
      tdwd_pkg::ST_DIV: begin
        if (div_i == DIV_CNT_W'(SUM_W)) begin
          state_next = tdwd_pkg::ST_DONE;
        end
      end
      tdwd_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = tdwd_pkg::ST_IDLE;
        end
      end
      default: state_next = tdwd_pkg::ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      spm <= tdwd_pkg::SPM_RESET;
      thr <= tdwd_pkg::THRESHOLD_RESET;
      wi <= '0;
      fill <= '0;
      detecting <= 1'b0;
      count <= '0;
      saved_avg <= '0;
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tdwd_pkg::CFG_SAMPLES_PER_MINUTE) begin
          spm <= cfg_data[3:0];
        end else if (cfg_index == tdwd_pkg::CFG_DROP_THRESHOLD) begin
          thr <= cfg_data;
        end
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        tdwd_pkg::ST_IDLE: begin
          if (ram_we) begin
            wi <= (wi == LAST_IDX) ? '0 : wi + IDX_W'(1);
            if (fill != DEPTH_F) begin
              fill <= fill + FILL_W'(1);
            end
          end
          if (accept && detecting && (count != tdwd_pkg::COUNT_MAX)) begin
            count <= count + 9'd1;
          end
        end
        tdwd_pkg::ST_START: begin
          pend <= 1'b0;
          if (win_bad) begin
            saved_avg <= tdwd_pkg::NO_READING;
          end
        end
        tdwd_pkg::ST_SUM: begin
          pend <= (n != win_len);
          if ((n == win_len) && !pend && (cnt == '0)) begin
            saved_avg <= tdwd_pkg::NO_READING;
          end
        end
        tdwd_pkg::ST_DIV: begin
          if (div_i == DIV_CNT_W'(SUM_W)) begin
            saved_avg <= quo_res[15:0];
          end
        end
        tdwd_pkg::ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            detecting <= det_new;
            if (!mode_det && check) begin
              count <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      tdwd_pkg::ST_IDLE: begin
        if (accept) begin
          sample <= temperature_sample;
          mode_det <= detecting;
          computed <= !(detecting && !rise);
        end
      end
      tdwd_pkg::ST_START: begin
        ptr <= win_from;
        n <= '0;
        sum <= '0;
        cnt <= '0;
      end
      tdwd_pkg::ST_SUM: begin
        if (n != win_len) begin
          pend_ok <= FILL_W'(ptr) < fill;
          ptr <= (ptr == LAST_IDX) ? '0 : ptr + IDX_W'(1);
          n <= n + WIN_W'(1);
        end
        if (pend && pend_ok) begin
          sum <= sum + {{(SUM_W - 16){rdata[15]}}, rdata};
          cnt <= cnt + FILL_W'(1);
        end
        quo <= sum_mag;
        rem <= '0;
        neg <= sum[SUM_W-1];
        div_i <= '0;
      end
      tdwd_pkg::ST_DIV: begin
        if (div_i != DIV_CNT_W'(SUM_W)) begin
          rem <= q_bit ? FILL_W'(rem_sh - {1'b0, cnt}) : rem_sh[FILL_W-1:0];
          quo <= {quo[SUM_W-2:0], q_bit};
          div_i <= div_i + DIV_CNT_W'(1);
        end
      end
      tdwd_pkg::ST_DONE: begin
        if (out_free) begin
          drop_detected <= det_new;
          reference_average <= saved_avg;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int INVALID_LEVEL = $signed(tdwd_pkg::NO_READING);
  // Indexes beyond the register list; writes to them must change nothing.
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic        drop;
    logic [15:0] average;
  } reading_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] temperature_sample;
  logic        out_valid;
  logic        out_stall;
  logic        drop_detected;
  logic [15:0] reference_average;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  temperature_drop_window_detector dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .temperature_sample(temperature_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .drop_detected(drop_detected),
    .reference_average(reference_average),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Mirror of the detector state and its settings.
  int unsigned        spm_setting;
  int                 threshold_setting;
  logic signed [15:0] history [tdwd_pkg::RING_DEPTH];
  int unsigned        history_wr;
  bit                 drop_flag;
  int unsigned        probes_flagged;
  int                 last_average;

  reading_t    expected_readings [$];
  int unsigned mismatch_count;
  int unsigned probes_sent;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_mirror();
    spm_setting = tdwd_pkg::SPM_RESET;
    threshold_setting = $signed(tdwd_pkg::THRESHOLD_RESET);
    for (int i = 0; i < tdwd_pkg::RING_DEPTH; i++) history[i] = tdwd_pkg::NO_READING;
    history_wr = 0;
    drop_flag = 1'b0;
    probes_flagged = 0;
    last_average = 0;
  endfunction

  function automatic int window_average();
    int unsigned len;
    int unsigned off;
    int unsigned from;
    int          total;
    int          valid_cnt;
    int          v;
    len = 10 * spm_setting;
    off = (13 * spm_setting) % tdwd_pkg::RING_DEPTH;
    from = (history_wr + tdwd_pkg::RING_DEPTH - off) % tdwd_pkg::RING_DEPTH;
    if (len == 0 || len > tdwd_pkg::RING_DEPTH) return INVALID_LEVEL;
    total = 0;
    valid_cnt = 0;
    for (int i = 0; i < len; i++) begin
      v = history[(from + i) % tdwd_pkg::RING_DEPTH];
      if (v > INVALID_LEVEL) begin
        total += v;
        valid_cnt++;
      end
    end
    if (valid_cnt == 0) return INVALID_LEVEL;
    return total / valid_cnt;
  endfunction

  function automatic bit refresh_and_test_drop(int level);
    last_average = window_average();
    return last_average > INVALID_LEVEL && (level - last_average) < threshold_setting;
  endfunction

  function automatic void predict_probe(logic [15:0] raw);
    int       level;
    reading_t r;
    level = $signed(raw);
    if (level > INVALID_LEVEL) begin
      history[history_wr] = raw;
      history_wr = (history_wr + 1) % tdwd_pkg::RING_DEPTH;
    end
    if (drop_flag) begin
      if (probes_flagged < tdwd_pkg::COUNT_MAX) probes_flagged++;
      // A rise past half the threshold triggers a fresh look at the window.
      if ((level - last_average) > threshold_setting / 2) begin
        if (!refresh_and_test_drop(level)) drop_flag = 1'b0;
      end
      if (drop_flag && probes_flagged > 30 * spm_setting) drop_flag = 1'b0;
    end else if (refresh_and_test_drop(level)) begin
      drop_flag = 1'b1;
      probes_flagged = 0;
    end
    r.drop = drop_flag;
    r.average = last_average[15:0];
    expected_readings.push_back(r);
  endfunction

  task automatic send_probe(logic [15:0] value);
    // A register write that came just before is over once a probe follows.
    cfg_valid <= 1'b0;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    temperature_sample <= value;
    do @(posedge clk); while (in_stall);
    predict_probe(value);
    probes_sent++;
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == tdwd_pkg::CFG_SAMPLES_PER_MINUTE) spm_setting = value[3:0];
    else if (idx == tdwd_pkg::CFG_DROP_THRESHOLD) threshold_setting = $signed(value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] noisy_probe(int level);
    int jitter;
    int v;
    jitter = $urandom_range(60, 0);
    if ($urandom_range(99, 0) < 6) return tdwd_pkg::NO_READING;
    v = level + jitter - 30;
    if (v > 32767) v = 32767;
    if (v < -32767) v = -32767;
    return v[15:0];
  endfunction

  // Reset settings, the largest probe value, zero, minus one, and an invalid probe on a nearly empty ring.
  task automatic test_startup_defaults();
    send_probe(16'h7FFF);
    send_probe(tdwd_pkg::NO_READING);
    send_probe(16'h0000);
    send_probe(16'hFFFF);
  endtask

  // A drop against a short window, an invalid probe while flagged, a rise that
  // releases the flag, and an invalid probe compared while idle.
  task automatic test_drop_and_release();
    wait_drained();
    write_register(tdwd_pkg::CFG_SAMPLES_PER_MINUTE, 16'hFFF1);
    write_register(tdwd_pkg::CFG_DROP_THRESHOLD, 16'hFF38);
    repeat (5) send_probe(16'd1000);
    send_probe(16'd400);
    send_probe(tdwd_pkg::NO_READING);
    send_probe(16'd1000);
    send_probe(16'd1000);
    send_probe(tdwd_pkg::NO_READING);
  endtask

  // Empty window with a flag pending, windows longer than the ring, offsets
  // that wrap, and both threshold extremes.
  task automatic test_window_limits();
    wait_drained();
    write_register(tdwd_pkg::CFG_SAMPLES_PER_MINUTE, 16'd0);
    send_probe(16'd0);
    wait_drained();
    write_register(tdwd_pkg::CFG_DROP_THRESHOLD, 16'h7FFF);
    write_register(tdwd_pkg::CFG_SAMPLES_PER_MINUTE, 16'd15);
    send_probe(16'd100);
    wait_drained();
    write_register(tdwd_pkg::CFG_SAMPLES_PER_MINUTE, 16'd13);
    send_probe(-16'sd100);
    wait_drained();
    write_register(tdwd_pkg::CFG_SAMPLES_PER_MINUTE, 16'd10);
    send_probe(16'd50);
    wait_drained();
    write_register(tdwd_pkg::CFG_SAMPLES_PER_MINUTE, 16'd12);
    send_probe(16'd50);
    wait_drained();
    write_register(tdwd_pkg::CFG_DROP_THRESHOLD, 16'h8000);
    send_probe(tdwd_pkg::NO_READING);
  endtask

  task automatic test_spare_register_indexes();
    wait_drained();
    write_register(CFG_SPARE_LO, 16'h0001);
    write_register(CFG_SPARE_HI, 16'h7FFF);
    send_probe(16'd900);
    send_probe(16'd200);
  endtask

  // Steady readings, a sudden drop held for a while, then recovery, with
  // bursts of arbitrary values in between.
  task automatic test_drop_episodes(int unsigned sender_pct, int unsigned stall_pct,
                                    logic [3:0] spm, int unsigned count);
    int unsigned stop_at;
    int          base;
    int          depth;
    wait_drained();
    send_idle_pct = sender_pct;
    recv_stall_pct = stall_pct;
    write_register(tdwd_pkg::CFG_SAMPLES_PER_MINUTE, {12'($urandom), spm});
    if ($urandom_range(7, 0) == 0) begin
      write_register(tdwd_pkg::CFG_DROP_THRESHOLD, 16'($urandom));
    end else begin
      write_register(tdwd_pkg::CFG_DROP_THRESHOLD, 16'(-$urandom_range(2500, 20)));
    end
    stop_at = probes_sent + count;
    while (probes_sent < stop_at) begin
      if ($urandom_range(9, 0) == 0) begin
        repeat ($urandom_range(6, 1))
          if (probes_sent < stop_at) send_probe(16'($urandom));
      end else begin
        base = $urandom_range(6000, 0);
        base -= 3000;
        if (threshold_setting < 0) depth = $urandom_range(400, 1) - threshold_setting;
        else depth = $urandom_range(3000, 0);
        repeat ($urandom_range(14 * spm, 3))
          if (probes_sent < stop_at) send_probe(noisy_probe(base));
        repeat ($urandom_range(32 * spm, 1))
          if (probes_sent < stop_at) send_probe(noisy_probe(base - depth));
        repeat ($urandom_range(6 * spm, 2))
          if (probes_sent < stop_at) send_probe(noisy_probe(base));
      end
    end
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected transaction, drop_detected %0b reference_average %0d",
                   $time, drop_detected, $signed(reference_average));
          mismatch_count++;
        end else begin
          want = expected_readings.pop_front();
          if (drop_detected !== want.drop) begin
            $display("%0t: drop_detected expected %0b got %0b",
                     $time, want.drop, drop_detected);
            mismatch_count++;
          end
          if (reference_average !== want.average) begin
            $display("%0t: reference_average expected %0d got %0d",
                     $time, $signed(want.average), $signed(reference_average));
            mismatch_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    temperature_sample = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = tdwd_pkg::CFG_SAMPLES_PER_MINUTE;
    cfg_data = '0;
    mismatch_count = 0;
    probes_sent = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clear_mirror();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_startup_defaults();
    test_drop_and_release();
    test_window_limits();
    test_spare_register_indexes();
    test_drop_episodes(0, 0, 4'd1, 200);
    test_drop_episodes(49, 0, 4'd3, 200);
    test_drop_episodes(0, 49, 4'd9, 200);
    test_drop_episodes(23, 23, 4'($urandom_range(9, 1)), 200);

    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
